// ===== design/irc_fmt_pkg.sv =====
// irc_fmt_pkg: shared types, control-code constants and the color palette
// for the irc format attribute decoder; no dependencies

package irc_fmt_pkg;

  // control and delimiter bytes
  localparam logic [7:0] CH_BOLD      = 8'd2;
  localparam logic [7:0] CH_COLOR     = 8'd3;
  localparam logic [7:0] CH_PLAIN     = 8'd15;
  localparam logic [7:0] CH_REVERSE   = 8'd22;
  localparam logic [7:0] CH_UNDERLINE = 8'd31;
  localparam logic [7:0] CH_COMMA     = 8'd44;
  localparam logic [7:0] CH_DIGIT_LO  = 8'd48;
  localparam logic [7:0] CH_DIGIT_HI  = 8'd57;

  // configuration register indexes
  localparam logic CFG_DEFAULT_FG = 1'b0;
  localparam logic CFG_DEFAULT_BG = 1'b1;

  localparam int unsigned RGB_W = 24;
  localparam int unsigned NUM_W = 7;

  typedef logic [RGB_W-1:0] rgb_t;
  typedef logic [NUM_W-1:0] num_t;

  // position inside a color spec
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_FG1   = 3'd2,
    PH_FG2   = 3'd3,
    PH_COMMA = 3'd4,
    PH_BG1   = 3'd5
  } phase_t;

  localparam rgb_t PALETTE [16] = '{
    24'hFFFFFF, 24'h000000, 24'h000080, 24'h008000,
    24'hFF0000, 24'h800000, 24'h800080, 24'hFFA500,
    24'hFFFF00, 24'h00FF00, 24'h008080, 24'h00FFFF,
    24'h0000FF, 24'hFF00FF, 24'h808080, 24'hC0C0C0
  };

  function automatic rgb_t palette_rgb(input logic [3:0] idx);
    return PALETTE[idx];
  endfunction

  // n * 10 + d for a single-digit n
  function automatic num_t append_digit(input num_t n, input logic [3:0] d);
    num_t n8;
    num_t n2;
    n8 = {n[3:0], 3'b000};
    n2 = {2'b00, n[3:0], 1'b0};
    return n8 + n2 + {3'b000, d};
  endfunction

endpackage

// ===== design/irc_format_attribute_decoder_top.sv =====
// irc_format_attribute_decoder_top: decodes irc formatting codes in a byte
// stream and tags printable bytes with color, bold and underline
// depends on irc_fmt_pkg
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   in       | in_valid / in_stall  | char_in, text_end
//   out      | out_valid / out_stall| char_out, fg_rgb, bg_on, bg_rgb,
//            |                      | bold_out, underline_out
//   config   | cfg_write            | cfg_index, cfg_data
//
// one byte per cycle sustained while out_stall is low; a byte goes from the input
// register through the decode logic into the result register
// the input register holds one byte while a stalled result waits, so a new
// transfer is taken even while out_stall is high
// in_stall rises only when the input register is full and its byte has a
// result that cannot enter the held result register
// rst is synchronous; config defaults go to black on white

module irc_format_attribute_decoder_top
  import irc_fmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  input  logic        text_end,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_out,
  output logic [23:0] fg_rgb,
  output logic        bg_on,
  output logic [23:0] bg_rgb,
  output logic        bold_out,
  output logic        underline_out
);

  // config registers
  rgb_t default_fg;
  rgb_t default_bg;

  // input register
  logic       in_q_valid;
  logic [7:0] char_q;
  logic       end_q;

  // formatting state
  logic   bold_flag, underline_flag, reverse_flag;
  logic   fg_custom_flag, bg_custom_flag;
  logic   text_started;
  rgb_t   saved_fg, saved_bg, shown_fg, shown_bg;
  logic   shown_bg_on;
  phase_t code_phase;
  num_t   fg_number, bg_number;

  // next state
  logic   bold_flag_next, underline_flag_next, reverse_flag_next;
  logic   fg_custom_flag_next, bg_custom_flag_next;
  logic   text_started_next;
  rgb_t   saved_fg_next, saved_bg_next, shown_fg_next, shown_bg_next;
  logic   shown_bg_on_next;
  phase_t code_phase_next;
  num_t   fg_number_next, bg_number_next;

  // decode result
  logic res_valid;
  rgb_t res_fg, res_bg;
  logic res_bg_on, res_bold, res_uline;
  logic advance;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      default_fg <= 24'h000000;
      default_bg <= 24'hFFFFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEFAULT_FG: default_fg <= cfg_data;
        CFG_DEFAULT_BG: default_bg <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode of the held byte against the current state
  always_comb begin
    logic       digit;
    logic [3:0] dval;
    logic       consumed;
    logic       fin, fin_fg, fin_bg;

    bold_flag_next      = bold_flag;
    underline_flag_next = underline_flag;
    reverse_flag_next   = reverse_flag;
    fg_custom_flag_next = fg_custom_flag;
    bg_custom_flag_next = bg_custom_flag;
    text_started_next   = text_started;
    saved_fg_next       = saved_fg;
    saved_bg_next       = saved_bg;
    shown_fg_next       = shown_fg;
    shown_bg_next       = shown_bg;
    shown_bg_on_next    = shown_bg_on;
    code_phase_next     = code_phase;
    fg_number_next      = fg_number;
    bg_number_next      = bg_number;
    res_valid           = 1'b0;
    res_fg              = '0;
    res_bg              = '0;
    res_bg_on           = 1'b0;
    res_bold            = 1'b0;
    res_uline           = 1'b0;

    digit    = (char_q >= CH_DIGIT_LO) && (char_q <= CH_DIGIT_HI);
    dval     = char_q[3:0];
    consumed = 1'b0;
    fin      = 1'b0;
    fin_fg   = 1'b0;
    fin_bg   = 1'b0;

    // first byte of a text picks up the current defaults
    if (!text_started) begin
      shown_fg_next     = default_fg;
      shown_bg_on_next  = 1'b0;
      text_started_next = 1'b1;
    end

    // color spec parsing
    case (code_phase)
      PH_IDLE: ;
      PH_START: begin
        if (digit) begin
          fg_number_next  = {3'b000, dval};
          code_phase_next = PH_FG1;
          consumed        = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      PH_FG1: begin
        if (digit) begin
          fg_number_next  = append_digit(fg_number, dval);
          code_phase_next = PH_FG2;
          consumed        = 1'b1;
        end else if (char_q == CH_COMMA) begin
          code_phase_next = PH_COMMA;
          consumed        = 1'b1;
        end else begin
          fin    = 1'b1;
          fin_fg = 1'b1;
        end
      end
      PH_FG2: begin
        if (char_q == CH_COMMA) begin
          code_phase_next = PH_COMMA;
          consumed        = 1'b1;
        end else begin
          fin    = 1'b1;
          fin_fg = 1'b1;
        end
      end
      PH_COMMA: begin
        if (digit) begin
          bg_number_next  = {3'b000, dval};
          code_phase_next = PH_BG1;
          consumed        = 1'b1;
        end else begin
          fin    = 1'b1;
          fin_fg = 1'b1;
        end
      end
      PH_BG1: begin
        if (digit) begin
          bg_number_next = append_digit(bg_number, dval);
          consumed       = 1'b1;
        end
        fin    = 1'b1;
        fin_fg = 1'b1;
        fin_bg = 1'b1;
      end
      default: code_phase_next = PH_IDLE;
    endcase

    // apply a finished spec
    if (fin) begin
      if (fin_fg) begin
        if (fg_number_next < num_t'(16)) begin
          fg_custom_flag_next = 1'b1;
          saved_fg_next       = palette_rgb(fg_number_next[3:0]);
          shown_fg_next       = palette_rgb(fg_number_next[3:0]);
        end
      end else begin
        fg_custom_flag_next = 1'b0;
        bg_custom_flag_next = 1'b0;
        shown_fg_next       = default_fg;
        shown_bg_on_next    = 1'b0;
      end
      if (fin_bg && (bg_number_next < num_t'(16))) begin
        bg_custom_flag_next = 1'b1;
        saved_bg_next       = palette_rgb(bg_number_next[3:0]);
        shown_bg_next       = palette_rgb(bg_number_next[3:0]);
        shown_bg_on_next    = 1'b1;
      end
      code_phase_next = PH_IDLE;
    end

    // control codes and printable bytes
    if (!consumed) begin
      case (char_q)
        CH_BOLD: bold_flag_next = !bold_flag_next;
        CH_UNDERLINE: underline_flag_next = !underline_flag_next;
        CH_PLAIN: begin
          shown_fg_next       = default_fg;
          shown_bg_on_next    = 1'b0;
          bold_flag_next      = 1'b0;
          underline_flag_next = 1'b0;
          reverse_flag_next   = 1'b0;
          fg_custom_flag_next = 1'b0;
          bg_custom_flag_next = 1'b0;
        end
        CH_REVERSE: begin
          if (!reverse_flag_next) begin
            reverse_flag_next = 1'b1;
            shown_fg_next     = default_bg;
            shown_bg_next     = default_fg;
            shown_bg_on_next  = 1'b1;
          end else begin
            reverse_flag_next = 1'b0;
            shown_fg_next     = fg_custom_flag_next ? saved_fg_next : default_fg;
            if (bg_custom_flag_next) begin
              shown_bg_next    = saved_bg_next;
              shown_bg_on_next = 1'b1;
            end else begin
              shown_bg_on_next = 1'b0;
            end
          end
        end
        CH_COLOR: begin
          if (!reverse_flag_next) begin
            code_phase_next = PH_START;
            fg_number_next  = '0;
            bg_number_next  = '0;
          end
        end
        default: begin
          // attributes as they stand for this byte, before any end-of-text clear
          res_valid = 1'b1;
          res_fg    = shown_fg_next;
          res_bg_on = shown_bg_on_next;
          res_bg    = shown_bg_on_next ? shown_bg_next : '0;
          res_bold  = bold_flag_next;
          res_uline = underline_flag_next;
        end
      endcase
    end

    // end of text clears everything for the next one
    if (end_q) begin
      bold_flag_next      = 1'b0;
      underline_flag_next = 1'b0;
      reverse_flag_next   = 1'b0;
      fg_custom_flag_next = 1'b0;
      bg_custom_flag_next = 1'b0;
      shown_fg_next       = default_fg;
      shown_bg_on_next    = 1'b0;
      code_phase_next     = PH_IDLE;
      fg_number_next      = '0;
      bg_number_next      = '0;
      text_started_next   = 1'b0;
    end
  end

  // the held byte moves on unless its result hits a stalled result register
  assign advance  = in_q_valid && (!res_valid || !out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_q <= char_in;
      end_q  <= text_end;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bold_flag      <= 1'b0;
      underline_flag <= 1'b0;
      reverse_flag   <= 1'b0;
      fg_custom_flag <= 1'b0;
      bg_custom_flag <= 1'b0;
      shown_bg_on    <= 1'b0;
      text_started   <= 1'b0;
      code_phase     <= PH_IDLE;
      fg_number      <= '0;
      bg_number      <= '0;
    end else if (advance) begin
      bold_flag      <= bold_flag_next;
      underline_flag <= underline_flag_next;
      reverse_flag   <= reverse_flag_next;
      fg_custom_flag <= fg_custom_flag_next;
      bg_custom_flag <= bg_custom_flag_next;
      shown_bg_on    <= shown_bg_on_next;
      text_started   <= text_started_next;
      code_phase     <= code_phase_next;
      fg_number      <= fg_number_next;
      bg_number      <= bg_number_next;
    end
  end

  // color state, only read once written
  always_ff @(posedge clk) begin
    if (advance) begin
      saved_fg <= saved_fg_next;
      saved_bg <= saved_bg_next;
      shown_fg <= shown_fg_next;
      shown_bg <= shown_bg_next;
    end
  end

  // result register; a waiting result stays until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      char_out      <= char_q;
      fg_rgb        <= res_fg;
      bg_on         <= res_bg_on;
      bg_rgb        <= res_bg;
      bold_out      <= res_bold;
      underline_out <= res_uline;
    end
  end

endmodule

// ===== design/irc_fmt_checker.sv =====
// irc_fmt_checker: port-level checks for the irc format attribute decoder
// and the bind that attaches them to the top level; no package needed

module irc_fmt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  char_out,
  input logic [23:0] fg_rgb,
  input logic        bg_on,
  input logic [23:0] bg_rgb,
  input logic        bold_out,
  input logic        underline_out
);

  // result register comes up empty after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(fg_rgb)
      && $stable(bg_on) && $stable(bg_rgb) && $stable(bold_out)
      && $stable(underline_out))
    else $error("stalled result changed");

  // no background means a zero background color
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !bg_on |-> bg_rgb == 24'h000000)
    else $error("background color without bg_on");

  // with the result register empty nothing blocks the input
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule

bind irc_format_attribute_decoder_top irc_fmt_checker u_irc_fmt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .char_out     (char_out),
  .fg_rgb       (fg_rgb),
  .bg_on        (bg_on),
  .bg_rgb       (bg_rgb),
  .bold_out     (bold_out),
  .underline_out(underline_out)
);

// ===== tb/attr_scoreboard_pkg.sv =====
// attr_scoreboard_pkg: result type and scoreboard class for the irc format
// attribute decoder bench; tracks formatting state and queues expected bytes
// depends on irc_fmt_pkg
`timescale 1ns / 100ps

package attr_scoreboard_pkg;
  import irc_fmt_pkg::*;

  // one tagged printable byte
  typedef struct packed {
    logic [7:0] ch;
    rgb_t       fg;
    logic       bg_on;
    rgb_t       bg;
    logic       bold;
    logic       uline;
  } attr_t;

  // fixed 16-color table selected by color numbers
  localparam rgb_t COLOR_TABLE [16] = '{
    24'hFFFFFF, 24'h000000, 24'h000080, 24'h008000,
    24'hFF0000, 24'h800000, 24'h800080, 24'hFFA500,
    24'hFFFF00, 24'h00FF00, 24'h008080, 24'h00FFFF,
    24'h0000FF, 24'hFF00FF, 24'h808080, 24'hC0C0C0
  };

  localparam int unsigned MAX_PRINTED = 30;

  class attr_scoreboard;
    rgb_t        dflt_fg, dflt_bg;
    rgb_t        saved_fg, saved_bg, cur_fg, cur_bg;
    bit          bold, uline, rev, fg_cust, bg_cust, cur_bg_on, started;
    phase_t      phase;
    int unsigned fg_num, bg_num;
    attr_t       expected_q[$];
    int unsigned errors;

    function new();
      dflt_fg  = '0;
      dflt_bg  = 24'hFFFFFF;
      saved_fg = '0;
      saved_bg = '0;
      cur_bg   = '0;
      errors   = 0;
      clear_text();
    endfunction

    function void write_reg(logic idx, rgb_t value);
      if (idx == CFG_DEFAULT_FG) begin
        dflt_fg = value;
      end else begin
        dflt_bg = value;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // state after a text ends
    function void clear_text();
      bold      = 1'b0;
      uline     = 1'b0;
      rev       = 1'b0;
      fg_cust   = 1'b0;
      bg_cust   = 1'b0;
      cur_fg    = dflt_fg;
      cur_bg_on = 1'b0;
      phase     = PH_IDLE;
      fg_num    = 0;
      bg_num    = 0;
      started   = 1'b0;
    endfunction

    // apply a finished color spec; out-of-table numbers change nothing
    function void close_spec(bit have_fg, bit have_bg);
      if (have_fg) begin
        if (fg_num < 16) begin
          fg_cust  = 1'b1;
          saved_fg = COLOR_TABLE[fg_num];
          cur_fg   = saved_fg;
        end
      end else begin
        fg_cust   = 1'b0;
        bg_cust   = 1'b0;
        cur_fg    = dflt_fg;
        cur_bg_on = 1'b0;
      end
      if (have_bg && bg_num < 16) begin
        bg_cust   = 1'b1;
        saved_bg  = COLOR_TABLE[bg_num];
        cur_bg    = saved_bg;
        cur_bg_on = 1'b1;
      end
      phase = PH_IDLE;
    endfunction

    // one byte inside a color spec; returns 1 when the spec swallows it
    function bit spec_takes(logic [7:0] c);
      bit          digit;
      int unsigned d;
      digit = (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
      d = digit ? int'(c - CH_DIGIT_LO) : 0;
      case (phase)
        PH_START: begin
          if (digit) begin
            fg_num = d;
            phase  = PH_FG1;
            return 1'b1;
          end
          close_spec(1'b0, 1'b0);
          return 1'b0;
        end
        PH_FG1: begin
          if (digit) begin
            fg_num = fg_num * 10 + d;
            phase  = PH_FG2;
            return 1'b1;
          end
          if (c == CH_COMMA) begin
            phase = PH_COMMA;
            return 1'b1;
          end
          close_spec(1'b1, 1'b0);
          return 1'b0;
        end
        PH_FG2: begin
          if (c == CH_COMMA) begin
            phase = PH_COMMA;
            return 1'b1;
          end
          close_spec(1'b1, 1'b0);
          return 1'b0;
        end
        PH_COMMA: begin
          if (digit) begin
            bg_num = d;
            phase  = PH_BG1;
            return 1'b1;
          end
          close_spec(1'b1, 1'b0);
          return 1'b0;
        end
        PH_BG1: begin
          if (digit) begin
            bg_num = bg_num * 10 + d;
            close_spec(1'b1, 1'b1);
            return 1'b1;
          end
          close_spec(1'b1, 1'b1);
          return 1'b0;
        end
        default: begin
          phase = PH_IDLE;
          return 1'b0;
        end
      endcase
    endfunction

    // update formatting state for one accepted byte, queue its tagged copy
    function void note_input(logic [7:0] c, logic last);
      attr_t tagged_byte;
      if (!started) begin
        cur_fg    = dflt_fg;
        cur_bg_on = 1'b0;
        started   = 1'b1;
      end
      if (!(phase != PH_IDLE && spec_takes(c))) begin
        case (c)
          CH_BOLD: bold = !bold;
          CH_UNDERLINE: uline = !uline;
          CH_PLAIN: begin
            cur_fg    = dflt_fg;
            cur_bg_on = 1'b0;
            bold      = 1'b0;
            uline     = 1'b0;
            rev       = 1'b0;
            fg_cust   = 1'b0;
            bg_cust   = 1'b0;
          end
          CH_REVERSE: begin
            if (!rev) begin
              rev       = 1'b1;
              cur_fg    = dflt_bg;
              cur_bg    = dflt_fg;
              cur_bg_on = 1'b1;
            end else begin
              rev       = 1'b0;
              cur_fg    = fg_cust ? saved_fg : dflt_fg;
              cur_bg_on = bg_cust;
              if (bg_cust) cur_bg = saved_bg;
            end
          end
          CH_COLOR: begin
            // a color code while reversed is dropped
            if (!rev) begin
              phase  = PH_START;
              fg_num = 0;
              bg_num = 0;
            end
          end
          default: begin
            tagged_byte.ch    = c;
            tagged_byte.fg    = cur_fg;
            tagged_byte.bg_on = cur_bg_on;
            tagged_byte.bg    = cur_bg_on ? cur_bg : '0;
            tagged_byte.bold  = bold;
            tagged_byte.uline = uline;
            expected_q.push_back(tagged_byte);
          end
        endcase
      end
      // end of text closes any open spec, then everything is cleared
      if (last) begin
        if (phase != PH_IDLE) close_spec(phase != PH_START, phase == PH_BG1);
        clear_text();
      end
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(attr_t got);
      attr_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("char_out %0d arrived with nothing expected", got.ch));
        return;
      end
      want = expected_q.pop_front();
      if (got.ch !== want.ch)
        report($sformatf("char_out %0d, expected %0d", got.ch, want.ch));
      if (got.fg !== want.fg)
        report($sformatf("char %0d fg_rgb %h, expected %h", want.ch, got.fg, want.fg));
      if (got.bg_on !== want.bg_on)
        report($sformatf("char %0d bg_on %b, expected %b", want.ch, got.bg_on, want.bg_on));
      if (got.bg !== want.bg)
        report($sformatf("char %0d bg_rgb %h, expected %h", want.ch, got.bg, want.bg));
      if (got.bold !== want.bold)
        report($sformatf("char %0d bold_out %b, expected %b", want.ch, got.bold, want.bold));
      if (got.uline !== want.uline)
        report($sformatf("char %0d underline_out %b, expected %b",
                         want.ch, got.uline, want.uline));
    endtask

    task flag_leftovers();
      while (expected_q.size() != 0) begin
        report($sformatf("char %0d never came out", expected_q[0].ch));
        void'(expected_q.pop_front());
      end
    endtask
  endclass

endpackage

// ===== tb/testbench.sv =====
// testbench: random and directed byte streams through the irc format
// attribute decoder, checked transfer by transfer against attr_scoreboard
// depends on irc_fmt_pkg, attr_scoreboard_pkg and the decoder rtl
`timescale 1ns / 100ps

module testbench;
  import irc_fmt_pkg::*;
  import attr_scoreboard_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 110;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned NUM_PHASES      = 5;

  // opening stream: {text_end, char_in}
  localparam logic [8:0] DIRECTED_BYTES [30] = '{
    {1'b0, 8'd65},                     // plain byte, default colors
    {1'b0, 8'd0},                      // lowest byte is printable
    {1'b0, CH_BOLD},
    {1'b0, CH_UNDERLINE},
    {1'b0, 8'd66},
    {1'b0, CH_COLOR},                  // fg 4, bg 12
    {1'b0, CH_DIGIT_LO + 8'd4},
    {1'b0, CH_COMMA},
    {1'b0, CH_DIGIT_LO + 8'd1},
    {1'b0, CH_DIGIT_LO + 8'd2},
    {1'b0, 8'd67},
    {1'b0, CH_REVERSE},
    {1'b0, CH_COLOR},                  // dropped while reversed
    {1'b0, CH_DIGIT_LO + 8'd5},        // so the digit prints
    {1'b0, CH_REVERSE},                // back to the custom colors
    {1'b0, CH_COLOR},                  // fg 99 is off the table
    {1'b0, CH_DIGIT_LO + 8'd9},
    {1'b0, CH_DIGIT_LO + 8'd9},
    {1'b0, CH_COMMA},                  // comma eaten, no bg digit
    {1'b0, 8'd68},
    {1'b0, CH_COLOR},                  // comma with no fg ends the spec
    {1'b0, CH_COMMA},
    {1'b0, CH_PLAIN},
    {1'b0, CH_COLOR},
    {1'b0, CH_DIGIT_LO + 8'd7},
    {1'b0, CH_COMMA},
    {1'b1, 8'd255},                    // highest byte, last of its text
    {1'b0, CH_COLOR},
    {1'b1, CH_DIGIT_LO + 8'd3},        // text ends inside a spec
    {1'b0, 8'd69}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_in = '0;
  logic        text_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  char_out;
  logic [23:0] fg_rgb;
  logic        bg_on;
  logic [23:0] bg_rgb;
  logic        bold_out;
  logic        underline_out;

  attr_scoreboard sb = new();

  int unsigned tx_mode = 1;
  int unsigned rx_mode = 1;
  int unsigned rx_wait = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;

  irc_format_attribute_decoder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_in       (char_in),
    .text_end      (text_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .char_out      (char_out),
    .fg_rgb        (fg_rgb),
    .bg_on         (bg_on),
    .bg_rgb        (bg_rgb),
    .bold_out      (bold_out),
    .underline_out (underline_out)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // wait cycles per transfer: none, uniform, or mostly none
  function automatic int unsigned draw_wait(int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  function automatic logic rand_end();
    return $urandom_range(0, 39) == 0;
  endfunction

  // color number for a run of 0, 1 or 2 digits
  function automatic int unsigned pick_number(int unsigned n_digits);
    if (n_digits == 2)
      return ($urandom_range(0, 3) == 0) ? $urandom_range(16, 99) : $urandom_range(0, 15);
    return $urandom_range(0, 9);
  endfunction

  // note input transfers, check output transfers, drive out_stall
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(char_in, text_end);
      if (out_valid && !out_stall) begin
        sb.check_result({char_out, fg_rgb, bg_on, bg_rgb, bold_out, underline_out});
        rx_wait = draw_wait(rx_mode);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one input transfer after a random gap
  task automatic send_byte(logic [7:0] c, logic last);
    int unsigned gap;
    gap = draw_wait(tx_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    text_end <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_number(int unsigned n_digits, int unsigned num);
    if (n_digits == 2) send_byte(CH_DIGIT_LO + 8'(num / 10), rand_end());
    if (n_digits != 0) send_byte(CH_DIGIT_LO + 8'(num % 10), rand_end());
  endtask

  // color code, fg digits, optional comma and bg digits, then a text byte
  task automatic send_color_spec();
    int unsigned n_fg;
    int unsigned n_bg;
    n_fg = $urandom_range(0, 2);
    n_bg = $urandom_range(0, 2);
    send_byte(CH_COLOR, rand_end());
    send_number(n_fg, pick_number(n_fg));
    if (n_fg != 0 && $urandom_range(0, 2) != 0) begin
      send_byte(CH_COMMA, rand_end());
      send_number(n_bg, pick_number(n_bg));
    end else if (n_fg == 0 && $urandom_range(0, 7) == 0) begin
      send_byte(CH_COMMA, rand_end());
    end
    send_byte(8'($urandom_range(32, 126)), rand_end());
  endtask

  task automatic send_random_token();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      send_byte(8'($urandom_range(32, 126)), rand_end());
    else if (pick < 40) send_byte(8'($urandom_range(0, 255)), rand_end());
    else if (pick < 45) send_byte(CH_BOLD, rand_end());
    else if (pick < 50) send_byte(CH_UNDERLINE, rand_end());
    else if (pick < 54) send_byte(CH_PLAIN, rand_end());
    else if (pick < 62) send_byte(CH_REVERSE, rand_end());
    else if (pick < 92) send_color_spec();
    else                send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // hold the sender until every expected byte is out and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both default color registers on consecutive cycles
  task automatic set_defaults(rgb_t fg, rgb_t bg);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DEFAULT_FG;
    cfg_data  <= fg;
    @(posedge clk);
    sb.write_reg(CFG_DEFAULT_FG, fg);
    cfg_index <= CFG_DEFAULT_BG;
    cfg_data  <= bg;
    @(posedge clk);
    sb.write_reg(CFG_DEFAULT_BG, bg);
    cfg_write <= 1'b0;
  endtask

  // reset, directed stream, then random phases under several color settings
  initial begin
    int unsigned phase_idx;
    int unsigned target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);

    for (phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
      drain();
      case (phase_idx)
        0: set_defaults(24'hFFFFFF, 24'h000000);
        1: set_defaults(24'($urandom), 24'($urandom));
        2: set_defaults(24'h000000, 24'h000000);
        3: set_defaults(24'hFFFFFF, 24'hFFFFFF);
        default: set_defaults(24'($urandom), 24'($urandom));
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if ($urandom_range(0, 29) == 0) begin
          tx_mode = $urandom_range(0, 2);
          rx_mode = $urandom_range(0, 2);
        end
        if ($urandom_range(0, 99) == 0) drain();
        send_random_token();
      end
    end

    drain();
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
